/* src/rtdc_pkg.sv */
package rtdc_pkg;

  // Fraction bits of the temperature result.
  localparam int FRAC_BITS = 8;
  // Quotient bits produced by the divider (width of the temperature field).
  localparam int Q_BITS = 19;
  // Square root steps: one result bit per step over a 64-bit radicand.
  localparam int SQ_STEPS = 32;
  // Divider numerator width: 48-bit product shifted left by FRAC_BITS, plus a carry.
  localparam int NUM_W = 49 + FRAC_BITS;

  // Pipeline stage count: two front stages, radicand stage, square root steps,
  // denominator stage, numerator stage, divide steps, output register.
  localparam int NSTG = 2 + 1 + SQ_STEPS + 1 + 1 + Q_BITS + 1;

  // Scaled Callendar-Van Dusen coefficients.
  localparam logic [47:0] A_SQ_SCALED   = 48'd1527480889;
  localparam logic [47:0] FOUR_B_SCALED = 48'd231000000;
  localparam logic [21:0] A_X64_SCALED  = 22'd2501312;
  localparam logic [47:0] NUM_SCALE     = 48'd1280000000;

  localparam logic [18:0] T_MAX     = 19'h3FFFF;
  localparam logic [18:0] T_MIN     = 19'h40000;
  localparam logic [18:0] T_NEG_LIM = 19'd131072;

  localparam logic [15:0] REF_RESET = 16'd4300;
  localparam logic [9:0]  NOM_RESET = 10'd1000;

  typedef enum logic {
    REG_REF_RES = 1'b0,
    REG_NOM_RES = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [15:0] res_ohms;
    logic        dneg;
    logic        zero;
    logic        neg;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [9:0]  r0;
    logic [16:0] mag;
    logic [63:0] v;
    logic [63:0] res;
  } sq_t;

  typedef struct packed {
    side_t       side;
    logic [33:0] den;
    logic [47:0] nump;
  } dn_t;

  typedef struct packed {
    side_t             side;
    logic [33:0]       den;
    logic [NUM_W-1:0]  rem;
    logic [Q_BITS-1:0] q;
    logic              ovf;
  } dv_t;

  // One step of the digit-by-digit integer square root.
  function automatic sq_t sqrt_step(input sq_t s, input int i);
    sq_t         o;
    logic [63:0] bitv;
    logic [63:0] trial;
    o     = s;
    bitv  = 64'd1 << (62 - 2 * i);
    trial = s.res + bitv;
    if (s.v >= trial) begin
      o.v   = s.v - trial;
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // One step of restoring division, most significant quotient bit first.
  function automatic dv_t div_step(input dv_t s, input int j);
    dv_t              o;
    logic [NUM_W-1:0] dsh;
    o   = s;
    dsh = NUM_W'(s.den) << (Q_BITS - 1 - j);
    if (s.rem >= dsh) begin
      o.rem = s.rem - dsh;
      o.q   = {s.q[Q_BITS-2:0], 1'b1};
    end else begin
      o.q   = {s.q[Q_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* src/rtd_code_to_temperature.sv */
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall  raw_code
// out       result     out_valid/out_stall  temperature_q8, resistance_ohms, out_of_range
// cfg       write      cfg_write_en         cfg_index, cfg_data
//
// An accepted request passes through every register stage to its result; one request can be
// taken every cycle while in_stall is low. The depth is set by the square root (32 steps, one result bit
// each) and the divider (19 steps, one quotient bit each), every step a register stage.
// Reset (rst, synchronous) empties the pipeline and loads the default resistances.
// A stall on the output holds the output register; stages upstream keep moving until
// they fill, so empty slots are squeezed out and nothing is lost or repeated.
module rtd_code_to_temperature (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        raw_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] temperature_q8,
  output logic [15:0]        resistance_ohms,
  output logic               out_of_range,
  input  logic               cfg_write_en,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NSTG = rtdc_pkg::NSTG;
  localparam int SQ0  = 2;
  localparam int DN   = SQ0 + rtdc_pkg::SQ_STEPS + 1;
  localparam int DV0  = DN + 1;
  localparam int OUTS = DV0 + rtdc_pkg::Q_BITS + 1;

  // Configuration registers.
  logic [15:0] ref_ohms;
  logic [9:0]  nom_ohms;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_ohms <= rtdc_pkg::REF_RESET;
      nom_ohms <= rtdc_pkg::NOM_RESET;
    end else if (cfg_write_en) begin
      case (rtdc_pkg::reg_index_t'(cfg_index))
        rtdc_pkg::REG_REF_RES: ref_ohms <= cfg_data;
        rtdc_pkg::REG_NOM_RES: nom_ohms <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data. A stage loads when it is empty or when the
  // stage after it loads, so bubbles collapse behind a stalled output.
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   adv;

  assign adv[NSTG] = !out_stall;
  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_adv
      assign adv[k] = !vld[k] || adv[k+1];
    end
  endgenerate

  logic [NSTG-1:0] vld_next;
  assign vld_next = {vld[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld_next[i];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[OUTS];

  // Stage 0: resistance from the ratio code.
  logic [30:0] code_prod;
  logic [15:0] s0_r;
  logic [9:0]  s0_r0;

  assign code_prod = raw_code[15:1] * ref_ohms;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_r  <= code_prod[30:15];
      s0_r0 <= nom_ohms;
    end
  end

  // Stage 1: deviation from nominal and the scaled discriminant.
  logic signed [17:0] d18;
  logic signed [47:0] m_next;
  logic [16:0]        mag_next;
  logic signed [47:0] s1_m;
  logic [16:0]        s1_mag;
  logic [9:0]         s1_r0;
  rtdc_pkg::side_t    s1_side;

  always_comb begin
    d18      = $signed({2'b00, s0_r}) - $signed({8'd0, s0_r0});
    m_next   = $signed(rtdc_pkg::A_SQ_SCALED) * $signed({38'd0, s0_r0})
             - $signed(rtdc_pkg::FOUR_B_SCALED) * 48'(d18);
    mag_next = (d18 < 0) ? 17'(-d18) : 17'(d18);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_m          <= m_next;
      s1_mag        <= mag_next;
      s1_r0         <= s0_r0;
      s1_side.res_ohms <= s0_r;
      s1_side.dneg  <= d18 < 0;
      s1_side.zero  <= s0_r0 == 10'd0;
      s1_side.neg   <= m_next[47];
    end
  end

  // Stage 2: radicand m * R0 * 4096, forced to zero when the discriminant is negative.
  logic [50:0]      rad_prod;
  rtdc_pkg::sq_t    sq [rtdc_pkg::SQ_STEPS+1];

  assign rad_prod = s1_m[40:0] * s1_r0;

  always_ff @(posedge clk) begin
    if (adv[SQ0]) begin
      sq[0].side     <= s1_side;
      sq[0].r0       <= s1_r0;
      sq[0].mag      <= s1_mag;
      sq[0].v        <= s1_m[47] ? 64'd0 : {1'b0, rad_prod, 12'd0};
      sq[0].res      <= 64'd0;
    end
  end

  // Square root, one result bit per stage.
  generate
    for (k = 0; k < rtdc_pkg::SQ_STEPS; k++) begin : g_sqrt
      always_ff @(posedge clk) begin
        if (adv[SQ0+1+k]) begin
          sq[k+1] <= rtdc_pkg::sqrt_step(sq[k], k);
        end
      end
    end
  endgenerate

  // Denominator and unscaled numerator.
  rtdc_pkg::dn_t dn;
  rtdc_pkg::sq_t sql;
  assign sql = sq[rtdc_pkg::SQ_STEPS];

  always_ff @(posedge clk) begin
    if (adv[DN]) begin
      dn.side <= sql.side;
      dn.den  <= 34'(sql.r0 * rtdc_pkg::A_X64_SCALED) + 34'(sql.res[32:0]);
      dn.nump <= 48'(sql.mag) * rtdc_pkg::NUM_SCALE;
    end
  end

  // Rounded numerator and the quotient overflow test.
  logic [rtdc_pkg::NUM_W-1:0] num_rnd;
  rtdc_pkg::dv_t              dv [rtdc_pkg::Q_BITS+1];

  assign num_rnd = (rtdc_pkg::NUM_W'(dn.nump) << rtdc_pkg::FRAC_BITS)
                 + rtdc_pkg::NUM_W'(dn.den >> 1);

  always_ff @(posedge clk) begin
    if (adv[DV0]) begin
      dv[0].side <= dn.side;
      dv[0].den  <= dn.den;
      dv[0].rem  <= num_rnd;
      dv[0].q    <= '0;
      dv[0].ovf  <= num_rnd >= (rtdc_pkg::NUM_W'(dn.den) << rtdc_pkg::Q_BITS);
    end
  end

  generate
    for (k = 0; k < rtdc_pkg::Q_BITS; k++) begin : g_div
      always_ff @(posedge clk) begin
        if (adv[DV0+1+k]) begin
          dv[k+1] <= rtdc_pkg::div_step(dv[k], k);
        end
      end
    end
  endgenerate

  // Sign, clamp and the output register.
  rtdc_pkg::dv_t dvl;
  logic [18:0]   t_next;
  logic          flag_next;

  assign dvl = dv[rtdc_pkg::Q_BITS];

  always_comb begin
    t_next    = 19'd0;
    flag_next = 1'b0;
    if (dvl.side.zero) begin
      flag_next = 1'b1;
    end else if (dvl.side.neg) begin
      t_next    = rtdc_pkg::T_MAX;
      flag_next = 1'b1;
    end else if (dvl.side.dneg) begin
      if (dvl.ovf || dvl.q > rtdc_pkg::T_NEG_LIM) begin
        t_next    = rtdc_pkg::T_MIN;
        flag_next = 1'b1;
      end else begin
        t_next = 19'(20'd0 - {1'b0, dvl.q});
      end
    end else begin
      if (dvl.ovf || dvl.q > rtdc_pkg::T_MAX) begin
        t_next    = rtdc_pkg::T_MAX;
        flag_next = 1'b1;
      end else begin
        t_next = dvl.q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUTS]) begin
      temperature_q8  <= $signed(t_next);
      resistance_ohms <= dvl.side.res_ohms;
      out_of_range    <= flag_next;
    end
  end

`ifndef SYNTHESIS
  // An accepted request always lands in the first stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted request not captured");

  // The square root remainder never exceeds twice the root.
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    vld[DN-1] |-> (sql.v <= (sql.res << 1)))
    else $error("square root remainder out of bound");

  // Without overflow and with a nonzero nominal resistance the divider remainder ends below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[OUTS-1] && !dvl.ovf && !dvl.side.zero) |->
      (dvl.rem < rtdc_pkg::NUM_W'(dvl.den)))
    else $error("divider remainder not below divisor");
`endif

endmodule
